@@ rtl/core/bba_pkg.sv @@
// package: shared types and constants of the buddy block allocator
`timescale 1ns / 1ps
package bba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 1024;
  localparam int unsigned ADDR_BITS_DEF  = 32;
  localparam int unsigned ORD_W          = 5;
  localparam int unsigned NUM_ORDERS     = 32;

  localparam logic [ORD_W-1:0] POOL_ORDER_RST  = 5'd20;
  localparam logic [ORD_W-1:0] BLOCK_ORDER_RST = 5'd10;
  localparam logic [ORD_W-1:0] POOL_ORDER_MIN  = 5'd4;
  localparam logic [ORD_W-1:0] BLOCK_ORDER_MIN = 5'd3;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_BLOCK = 2'd1;
  localparam logic [1:0] STAT_BAD_SIZE = 2'd2;
  localparam logic [1:0] STAT_BAD_FREE = 2'd3;

  localparam logic [1:0] CFG_POOL_BASE   = 2'd0;
  localparam logic [1:0] CFG_POOL_ORDER  = 2'd1;
  localparam logic [1:0] CFG_BLOCK_ORDER = 2'd2;

  typedef struct packed {
    logic             free;
    logic [ORD_W-1:0] order;
  } bba_meta_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_A_ORD,
    S_A_FIND,
    S_A_TAKE,
    S_A_SPLIT,
    S_RM_RD,
    S_RM_WR,
    S_PUSH_A,
    S_PUSH_B,
    S_F_CHK,
    S_F_NEXT,
    S_F_BCHK,
    S_F_END,
    S_Q_RD,
    S_DONE
  } bba_state_e;

endpackage

@@ rtl/core/bba_if.sv @@
// channel interfaces: request, response and configuration write
`timescale 1ns / 1ps
interface bba_req_if #(parameter int unsigned AW = 32);
  logic          valid;
  logic          ready;
  logic [1:0]    opcode;
  logic [AW-1:0] request_size;
  logic [AW-1:0] address;
  modport source(output valid, opcode, request_size, address, input ready);
  modport sink(input valid, opcode, request_size, address, output ready);
endinterface

interface bba_rsp_if #(parameter int unsigned AW = 32, parameter int unsigned UW = 11);
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic [AW-1:0] block_address;
  logic [4:0]    size_order;
  logic [UW-1:0] free_units;
  modport source(output valid, status, block_address, size_order, free_units, input ready);
  modport sink(input valid, status, block_address, size_order, free_units, output ready);
endinterface

interface bba_cfg_if #(parameter int unsigned AW = 32);
  logic          valid;
  logic          ready;
  logic [1:0]    index;
  logic [AW-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/core/buddy_block_allocator.sv @@
// buddy block allocator: sequencer over block metadata and free-list link memories
// clear pass after reset and after each base or order config write, no item taken then
// allocate: round size up to an order, search free lists upward, take block, split down
// free: check block, merge with free buddies, push unless whole pool; query reads order
// one item in flight, rejected items end early; an untaken result holds off the next item
// reset: async active low, config back to defaults, all free lists empty, pool unsplit
`timescale 1ns / 1ps
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  bba_cfg_if.sink   cfg_i,
  bba_req_if.sink   req_i,
  bba_rsp_if.source rsp_o
);

  localparam int unsigned IW  = $clog2(MAX_BLOCKS);
  localparam int unsigned UW  = IW + 1;
  localparam int unsigned LIM = $clog2(MAX_BLOCKS + 1) - 1;
  localparam int unsigned AW  = ADDR_BITS;
  localparam logic [UW-1:0] NO_UNIT = UW'(MAX_BLOCKS);

  bba_state_e state_q, state_d;

  logic [AW-1:0]    pool_base_q;
  logic [ORD_W-1:0] pool_order_q, block_order_q;
  logic [ORD_W-1:0] po, bo;

  logic [IW-1:0]  clr_q, clr_d;
  logic [UW-1:0]  alloc_q, alloc_d;
  logic [UW-1:0]  head_q [NUM_ORDERS];
  logic [UW-1:0]  head_d [NUM_ORDERS];
  logic           rsp_valid_q, rsp_valid_d;

  logic [1:0]       op_q, op_d;
  logic [AW-1:0]    size_q, size_d, addr_q, addr_d, rem_q, rem_d;
  logic [ORD_W-1:0] k_q, k_d, ord_q, ord_d;
  logic [IW-1:0]    blk_q, blk_d, tgt_q, tgt_d;
  logic [UW-1:0]    h_q, h_d, units_q, units_d;
  logic [1:0]       status_q, status_d;
  logic [AW-1:0]    baddr_q, baddr_d;
  logic [ORD_W-1:0] qord_q, qord_d;
  logic [1:0]       rsp_status_q;
  logic [AW-1:0]    rsp_addr_q;
  logic [ORD_W-1:0] rsp_ord_q;
  logic [UW-1:0]    rsp_fu_q;

  bba_meta_t     meta_mem [MAX_BLOCKS];
  logic [UW-1:0] nxt_mem [MAX_BLOCKS];
  logic [UW-1:0] prv_mem [MAX_BLOCKS];
  bba_meta_t     meta_rd_q, meta_wd;
  logic [UW-1:0] nxt_rd_q, prv_rd_q, nxt_wd, prv_wd;
  logic [IW-1:0] meta_ra, meta_wa, nxt_wa, prv_wa;
  logic          meta_we, nxt_we, prv_we;

  logic          cfg_init, req_acc, rsp_busy;
  logic [AW-1:0] off;
  logic          loc_ok;
  logic [IW-1:0] loc_idx;
  logic [UW-1:0] head_k;
  logic          head_k_vld, meta_bad, bud_ok;
  logic [IW-1:0] buddy, lo_blk, hi_blk;
  logic [UW-1:0] total, free_units;

  // effective geometry
  always_comb begin
    po = (pool_order_q < POOL_ORDER_MIN) ? POOL_ORDER_MIN : pool_order_q;
    bo = (block_order_q < BLOCK_ORDER_MIN) ? BLOCK_ORDER_MIN : block_order_q;
    if (bo >= po) bo = po - 5'd1;
    if ((po - bo) > ORD_W'(LIM)) bo = po - ORD_W'(LIM);
  end

  assign cfg_i.ready = 1'b1;
  assign cfg_init = cfg_i.valid && (cfg_i.index == CFG_POOL_BASE ||
                    cfg_i.index == CFG_POOL_ORDER || cfg_i.index == CFG_BLOCK_ORDER);
  assign req_i.ready = (state_q == S_IDLE) && !cfg_init;
  assign req_acc = req_i.valid && req_i.ready;
  assign rsp_busy = rsp_valid_q && !rsp_o.ready;

  assign off = addr_q - pool_base_q;
  assign loc_ok = (addr_q >= pool_base_q) && ((off >> po) == '0);
  assign loc_idx = IW'(off >> bo);

  assign head_k = head_q[k_q];
  assign head_k_vld = head_k < NO_UNIT;
  assign meta_bad = meta_rd_q.free || meta_rd_q.order == '0 ||
                    meta_rd_q.order > po || meta_rd_q.order < bo;
  assign bud_ok = meta_rd_q.free && meta_rd_q.order == k_q;
  assign buddy = blk_q ^ IW'(UW'(1) << (k_q - bo));
  assign lo_blk = (tgt_q < blk_q) ? tgt_q : blk_q;
  assign hi_blk = (tgt_q < blk_q) ? blk_q : tgt_q;
  assign total = UW'(1) << (po - bo);
  assign free_units = (total > alloc_q) ? total - alloc_q : '0;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:   if (clr_q == IW'(MAX_BLOCKS - 1)) state_d = S_IDLE;
      S_IDLE:    if (req_acc) state_d = S_DEC;
      S_DEC: begin
        case (op_q)
          OP_ALLOC: state_d = (size_q == '0) ? S_DONE : S_A_ORD;
          OP_FREE:  state_d = (addr_q == '0 || !loc_ok) ? S_DONE : S_F_CHK;
          OP_QUERY: state_d = loc_ok ? S_Q_RD : S_DONE;
          default:  state_d = S_DONE;
        endcase
      end
      S_A_ORD: begin
        if (rem_q == '0) state_d = (alloc_q != '0) ? S_A_FIND : S_A_TAKE;
        else if (k_q == po) state_d = S_DONE;
      end
      S_A_FIND: begin
        if (head_k_vld) state_d = S_RM_RD;
        else if (k_q == po) state_d = S_DONE;
      end
      S_RM_RD:   state_d = S_RM_WR;
      S_RM_WR:   state_d = (op_q == OP_ALLOC) ? S_A_TAKE : S_F_NEXT;
      S_A_TAKE:  state_d = S_A_SPLIT;
      S_A_SPLIT: state_d = (k_q > ord_q) ? S_PUSH_A : S_DONE;
      S_PUSH_A:  state_d = S_PUSH_B;
      S_PUSH_B:  state_d = (op_q == OP_ALLOC) ? S_A_SPLIT : S_DONE;
      S_F_CHK:   state_d = meta_bad ? S_DONE : S_F_NEXT;
      S_F_NEXT:  state_d = (k_q < po) ? S_F_BCHK : S_F_END;
      S_F_BCHK:  state_d = bud_ok ? S_RM_RD : S_F_END;
      S_F_END:   state_d = (k_q < po) ? S_PUSH_A : S_DONE;
      S_Q_RD:    state_d = S_DONE;
      S_DONE:    if (!rsp_busy) state_d = S_IDLE;
      default:   state_d = S_CLEAR;
    endcase
    if (cfg_init) state_d = S_CLEAR;
  end

  // datapath and memory control
  always_comb begin
    clr_d = clr_q;
    alloc_d = alloc_q;
    head_d = head_q;
    op_d = op_q;
    size_d = size_q;
    addr_d = addr_q;
    rem_d = rem_q;
    k_d = k_q;
    ord_d = ord_q;
    blk_d = blk_q;
    tgt_d = tgt_q;
    h_d = h_q;
    units_d = units_q;
    status_d = status_q;
    baddr_d = baddr_q;
    qord_d = qord_q;
    rsp_valid_d = rsp_valid_q;
    meta_we = 1'b0;
    meta_wa = blk_q;
    meta_wd = '0;
    meta_ra = loc_idx;
    nxt_we = 1'b0;
    nxt_wa = tgt_q;
    nxt_wd = head_k;
    prv_we = 1'b0;
    prv_wa = tgt_q;
    prv_wd = NO_UNIT;

    if (rsp_valid_q && rsp_o.ready) rsp_valid_d = 1'b0;

    case (state_q)
      S_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = clr_q;
        if (clr_q == '0) meta_wd = '{free: 1'b1, order: po};
        clr_d = clr_q + IW'(1);
      end
      S_IDLE: begin
        if (req_acc) begin
          op_d = req_i.opcode;
          size_d = req_i.request_size;
          addr_d = req_i.address;
          status_d = STAT_OK;
          baddr_d = '0;
          qord_d = '0;
        end
      end
      S_DEC: begin
        blk_d = loc_idx;
        case (op_q)
          OP_ALLOC: begin
            if (size_q == '0) status_d = STAT_BAD_SIZE;
            rem_d = (size_q - AW'(1)) >> bo;
            k_d = bo;
          end
          OP_FREE: if (addr_q != '0 && !loc_ok) status_d = STAT_BAD_FREE;
          default: ;
        endcase
      end
      S_A_ORD: begin
        if (rem_q == '0) begin
          ord_d = k_q;
          if (alloc_q == '0) begin
            blk_d = '0;
            k_d = po;
          end
        end else if (k_q == po) begin
          status_d = STAT_BAD_SIZE;
        end else begin
          rem_d = rem_q >> 1;
          k_d = k_q + 5'd1;
        end
      end
      S_A_FIND: begin
        if (head_k_vld) begin
          blk_d = head_k[IW-1:0];
          tgt_d = head_k[IW-1:0];
        end else if (k_q == po) begin
          status_d = STAT_NO_BLOCK;
        end else begin
          k_d = k_q + 5'd1;
        end
      end
      S_RM_WR: begin
        if (prv_rd_q < NO_UNIT) begin
          nxt_we = 1'b1;
          nxt_wa = prv_rd_q[IW-1:0];
          nxt_wd = nxt_rd_q;
        end else begin
          head_d[k_q] = nxt_rd_q;
        end
        if (nxt_rd_q < NO_UNIT) begin
          prv_we = 1'b1;
          prv_wa = nxt_rd_q[IW-1:0];
          prv_wd = prv_rd_q;
        end
        if (op_q != OP_ALLOC) begin
          meta_we = 1'b1;
          meta_wa = hi_blk;
          meta_wd = '0;
          blk_d = lo_blk;
          k_d = k_q + 5'd1;
        end
      end
      S_A_TAKE: begin
        meta_we = 1'b1;
        meta_wa = blk_q;
        meta_wd = '{free: 1'b0, order: ord_q};
        alloc_d = alloc_q + (UW'(1) << (ord_q - bo));
      end
      S_A_SPLIT: begin
        if (k_q > ord_q) begin
          k_d = k_q - 5'd1;
          tgt_d = blk_q + IW'(UW'(1) << (k_q - 5'd1 - bo));
          meta_we = 1'b1;
          meta_wa = blk_q + IW'(UW'(1) << (k_q - 5'd1 - bo));
          meta_wd = '{free: 1'b1, order: k_q - 5'd1};
        end else begin
          baddr_d = pool_base_q + (AW'(blk_q) << bo);
        end
      end
      S_PUSH_A: begin
        h_d = head_k;
        nxt_we = 1'b1;
        nxt_wa = tgt_q;
        nxt_wd = head_k;
        prv_we = 1'b1;
        prv_wa = tgt_q;
        prv_wd = NO_UNIT;
      end
      S_PUSH_B: begin
        if (h_q < NO_UNIT) begin
          prv_we = 1'b1;
          prv_wa = h_q[IW-1:0];
          prv_wd = UW'(tgt_q);
        end
        head_d[k_q] = UW'(tgt_q);
      end
      S_F_CHK: begin
        if (meta_bad) begin
          status_d = STAT_BAD_FREE;
        end else begin
          k_d = meta_rd_q.order;
          units_d = UW'(1) << (meta_rd_q.order - bo);
        end
      end
      S_F_NEXT: begin
        meta_ra = buddy;
        tgt_d = buddy;
      end
      S_F_END: begin
        meta_we = 1'b1;
        meta_wa = blk_q;
        meta_wd = '{free: 1'b1, order: k_q};
        alloc_d = (alloc_q > units_q) ? alloc_q - units_q : '0;
        tgt_d = blk_q;
      end
      S_Q_RD: qord_d = meta_rd_q.order;
      S_DONE: if (!rsp_busy) rsp_valid_d = 1'b1;
      default: ;
    endcase

    if (cfg_init) begin
      clr_d = '0;
      alloc_d = '0;
      for (int i = 0; i < NUM_ORDERS; i++) head_d[i] = NO_UNIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      alloc_q <= '0;
      rsp_valid_q <= 1'b0;
      pool_base_q <= '0;
      pool_order_q <= POOL_ORDER_RST;
      block_order_q <= BLOCK_ORDER_RST;
      for (int i = 0; i < NUM_ORDERS; i++) head_q[i] <= NO_UNIT;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      alloc_q <= alloc_d;
      rsp_valid_q <= rsp_valid_d;
      head_q <= head_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_POOL_BASE:   pool_base_q <= cfg_i.data;
          CFG_POOL_ORDER:  pool_order_q <= cfg_i.data[ORD_W-1:0];
          CFG_BLOCK_ORDER: block_order_q <= cfg_i.data[ORD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    size_q <= size_d;
    addr_q <= addr_d;
    rem_q <= rem_d;
    k_q <= k_d;
    ord_q <= ord_d;
    blk_q <= blk_d;
    tgt_q <= tgt_d;
    h_q <= h_d;
    units_q <= units_d;
    status_q <= status_d;
    baddr_q <= baddr_d;
    qord_q <= qord_d;
    if (state_q == S_DONE && !rsp_busy) begin
      rsp_status_q <= status_q;
      rsp_addr_q <= baddr_q;
      rsp_ord_q <= qord_q;
      rsp_fu_q <= free_units;
    end
  end

  // metadata and link memories
  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    meta_rd_q <= meta_mem[meta_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    nxt_rd_q <= nxt_mem[tgt_q];
  end

  always_ff @(posedge clk_i) begin
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    prv_rd_q <= prv_mem[tgt_q];
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.status = rsp_status_q;
  assign rsp_o.block_address = rsp_addr_q;
  assign rsp_o.size_order = rsp_ord_q;
  assign rsp_o.free_units = rsp_fu_q;

endmodule
